@@ src/dhtm_pkg.sv @@
// Package: widths, constants, types and arithmetic helpers for the DH transform block.
`default_nettype none

package dhtm_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int STAGES     = 30;
	localparam int SHIFT_W    = $clog2(STAGES);
	localparam int XY_W       = 34;
	localparam int Z_W        = 33;
	localparam int TRIG_W     = FRAC_BITS + 2;
	localparam int WORD_W     = 32;
	localparam int PROD_W     = WORD_W + TRIG_W;

	localparam logic [1:0] LAST_ROW = 2'd3;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

	localparam logic [31:0] ATAN_TURN [STAGES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} lane_t;

	typedef struct packed {
		logic                     valid;
		logic                     flip_t;
		logic                     flip_a;
		logic signed [WORD_W-1:0] d;
		logic signed [WORD_W-1:0] r;
	} side_t;

	typedef struct packed {
		lane_t lane;
		logic  flip;
	} fold_t;

	// scale to a 32-bit turn, fold into [-pi/2, pi/2]
	function automatic fold_t fold_angle(input logic [ANGLE_BITS-1:0] ang);
		localparam logic signed [Z_W-1:0] QUARTER = Z_W'(64'sd1073741824);
		localparam logic signed [Z_W-1:0] HALF    = Z_W'(64'sd2147483648);
		logic [31:0]           t;
		logic signed [Z_W-1:0] z;
		fold_t                 f;
		t = {ang, {(32-ANGLE_BITS){1'b0}}};
		z = $signed({t[31], t});
		f.flip = 1'b0;
		if (z > QUARTER) begin
			z = z - HALF;
			f.flip = 1'b1;
		end else if (z < -QUARTER) begin
			z = z + HALF;
			f.flip = 1'b1;
		end
		f.lane.x = CORDIC_GAIN;
		f.lane.y = '0;
		f.lane.z = z;
		return f;
	endfunction

	function automatic lane_t cordic_step(input lane_t l, input logic [SHIFT_W-1:0] sh,
			input logic [31:0] at);
		logic signed [XY_W-1:0] dx;
		logic signed [XY_W-1:0] dy;
		logic signed [Z_W-1:0]  a;
		lane_t                  o;
		dx = l.y >>> sh;
		dy = l.x >>> sh;
		a  = $signed({1'b0, at});
		if (!l.z[Z_W-1]) begin
			o.x = l.x - dx;
			o.y = l.y + dy;
			o.z = l.z - a;
		end else begin
			o.x = l.x + dx;
			o.y = l.y - dy;
			o.z = l.z + a;
		end
		return o;
	endfunction

	// Q30 to FRAC_BITS, round half up, clamp to [-1, 1]
	function automatic logic signed [TRIG_W-1:0] trig_round(input logic signed [XY_W-1:0] v,
			input logic flip);
		localparam logic signed [XY_W-1:0] RND     = XY_W'(1) <<< (29 - FRAC_BITS);
		localparam logic signed [XY_W-1:0] ONE     = XY_W'(1) <<< FRAC_BITS;
		localparam logic signed [XY_W-1:0] NEG_ONE = -ONE;
		logic signed [XY_W-1:0] s;
		s = flip ? -v : v;
		s = (s + RND) >>> (30 - FRAC_BITS);
		if (s > ONE)
			s = ONE;
		else if (s < NEG_ONE)
			s = NEG_ONE;
		return s[TRIG_W-1:0];
	endfunction

	// round half up, shift out fraction, saturate to 32 bits
	function automatic logic signed [WORD_W-1:0] fx_finish(input logic signed [PROD_W-1:0] p);
		localparam logic signed [PROD_W:0] RND     = (PROD_W+1)'(1) <<< (FRAC_BITS - 1);
		localparam logic signed [PROD_W:0] SAT_MAX = {{(PROD_W+2-WORD_W){1'b0}},
			{(WORD_W-1){1'b1}}};
		localparam logic signed [PROD_W:0] SAT_MIN = {{(PROD_W+2-WORD_W){1'b1}},
			{(WORD_W-1){1'b0}}};
		logic signed [PROD_W:0] s;
		s = ($signed({p[PROD_W-1], p}) + RND) >>> FRAC_BITS;
		if (s > SAT_MAX)
			s = SAT_MAX;
		else if (s < SAT_MIN)
			s = SAT_MIN;
		return s[WORD_W-1:0];
	endfunction

	function automatic logic signed [WORD_W-1:0] trig_word(input logic signed [TRIG_W-1:0] v);
		return WORD_W'(v);
	endfunction

endpackage

`default_nettype wire

@@ src/dhtm_cell.sv @@
// One CORDIC rotation cell: advances the theta and alpha lanes by one micro-rotation.
`default_nettype none

module dhtm_cell (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire [dhtm_pkg::SHIFT_W-1:0]  shift,
	input  wire [31:0]                   atan,
	input  wire dhtm_pkg::lane_t         th_in,
	input  wire dhtm_pkg::lane_t         al_in,
	input  wire dhtm_pkg::side_t         side_in,
	output dhtm_pkg::lane_t              th_out,
	output dhtm_pkg::lane_t              al_out,
	output dhtm_pkg::side_t              side_out
);
	import dhtm_pkg::*;

	lane_t th_q;
	lane_t al_q;
	side_t side_q;
	logic  valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= side_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		th_q   <= cordic_step(th_in, shift, atan);
		al_q   <= cordic_step(al_in, shift, atan);
		side_q <= side_in;
	end

	always_comb begin
		side_out       = side_q;
		side_out.valid = valid_q;
	end

	assign th_out = th_q;
	assign al_out = al_q;

endmodule

`default_nettype wire

@@ src/dhtm_row_out.sv @@
// Rounds sine/cosine, forms the products and sends the matrix out one row per cycle.
`default_nettype none

module dhtm_row_out (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire dhtm_pkg::lane_t          th_in,
	input  wire dhtm_pkg::lane_t          al_in,
	input  wire dhtm_pkg::side_t          side_in,
	output logic                          row_valid,
	output logic [1:0]                    row_index,
	output logic signed [dhtm_pkg::WORD_W-1:0] cell_col0,
	output logic signed [dhtm_pkg::WORD_W-1:0] cell_col1,
	output logic signed [dhtm_pkg::WORD_W-1:0] cell_col2,
	output logic signed [dhtm_pkg::WORD_W-1:0] cell_col3,
	output logic                          last_row
);
	import dhtm_pkg::*;

	localparam logic signed [WORD_W-1:0] ONE_W = WORD_W'(1) <<< FRAC_BITS;

	// stage 1: trig values
	logic                     valid_s1;
	logic signed [TRIG_W-1:0] st_s1, ct_s1, sa_s1, ca_s1;
	logic signed [WORD_W-1:0] d_s1, r_s1;

	// stage 2: products
	logic                     valid_s2;
	logic signed [TRIG_W-1:0] st_s2, ct_s2, sa_s2, ca_s2;
	logic signed [WORD_W-1:0] d_s2;
	logic signed [PROD_W-1:0] p01_s2, p02_s2, p03_s2, p11_s2, p12_s2, p13_s2;

	logic signed [TRIG_W-1:0] neg_st, neg_ct;

	// held rows 1 and 2
	logic signed [WORD_W-1:0] e10_q, e11_q, e12_q, e13_q, e21_q, e22_q, e23_q;
	logic                     active_q;
	logic [1:0]               cnt_q;

	logic                     row_valid_q, last_q;
	logic [1:0]               row_index_q;
	logic signed [WORD_W-1:0] col0_q, col1_q, col2_q, col3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= side_in.valid;
			valid_s2 <= valid_s1;
		end
	end

	assign neg_st = -st_s1;
	assign neg_ct = -ct_s1;

	always_ff @(posedge clk) begin
		st_s1  <= trig_round(th_in.y, side_in.flip_t);
		ct_s1  <= trig_round(th_in.x, side_in.flip_t);
		sa_s1  <= trig_round(al_in.y, side_in.flip_a);
		ca_s1  <= trig_round(al_in.x, side_in.flip_a);
		d_s1   <= side_in.d;
		r_s1   <= side_in.r;

		st_s2  <= st_s1;
		ct_s2  <= ct_s1;
		sa_s2  <= sa_s1;
		ca_s2  <= ca_s1;
		d_s2   <= d_s1;
		p01_s2 <= PROD_W'(neg_st) * PROD_W'(ca_s1);
		p02_s2 <= PROD_W'(st_s1) * PROD_W'(sa_s1);
		p03_s2 <= PROD_W'(r_s1) * PROD_W'(ct_s1);
		p11_s2 <= PROD_W'(ct_s1) * PROD_W'(ca_s1);
		p12_s2 <= PROD_W'(neg_ct) * PROD_W'(sa_s1);
		p13_s2 <= PROD_W'(r_s1) * PROD_W'(st_s1);
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			e10_q <= trig_word(st_s2);
			e11_q <= fx_finish(p11_s2);
			e12_q <= fx_finish(p12_s2);
			e13_q <= fx_finish(p13_s2);
			e21_q <= trig_word(sa_s2);
			e22_q <= trig_word(ca_s2);
			e23_q <= d_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			cnt_q       <= '0;
			row_valid_q <= 1'b0;
			row_index_q <= '0;
			last_q      <= 1'b0;
		end else begin
			row_valid_q <= valid_s2 | active_q;
			if (valid_s2) begin
				active_q    <= 1'b1;
				cnt_q       <= 2'd1;
				row_index_q <= 2'd0;
				last_q      <= 1'b0;
			end else if (active_q) begin
				cnt_q       <= cnt_q + 2'd1;
				row_index_q <= cnt_q;
				last_q      <= (cnt_q == LAST_ROW);
				if (cnt_q == LAST_ROW) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			col0_q <= trig_word(ct_s2);
			col1_q <= fx_finish(p01_s2);
			col2_q <= fx_finish(p02_s2);
			col3_q <= fx_finish(p03_s2);
		end else if (active_q) begin
			unique case (cnt_q)
				2'd1: begin
					col0_q <= e10_q;
					col1_q <= e11_q;
					col2_q <= e12_q;
					col3_q <= e13_q;
				end
				2'd2: begin
					col0_q <= '0;
					col1_q <= e21_q;
					col2_q <= e22_q;
					col3_q <= e23_q;
				end
				default: begin
					col0_q <= '0;
					col1_q <= '0;
					col2_q <= '0;
					col3_q <= ONE_W;
				end
			endcase
		end
	end

	assign row_valid = row_valid_q;
	assign row_index = row_index_q;
	assign last_row  = last_q;
	assign cell_col0 = col0_q;
	assign cell_col1 = col1_q;
	assign cell_col2 = col2_q;
	assign cell_col3 = col3_q;

	// a new matrix never lands on rows still going out
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !active_q)
		else $error("matrix arrived while rows pending");

	// rows of one matrix go out on consecutive cycles
	a_rows_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid_q && !last_q |=> row_valid_q && row_index_q == $past(row_index_q) + 2'd1)
		else $error("row sequence broken");

	// after the last row nothing goes out unless a new matrix came in
	a_quiet_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid_q && last_q && !$past(valid_s2) |=> !row_valid_q || row_index_q == 2'd0)
		else $error("row after last without new item");

endmodule

`default_nettype wire

@@ src/dh_transform_matrix.sv @@
// Top level: Denavit-Hartenberg link transform, CORDIC cell chain plus row output stage.
//
// An item (theta, d, r, alpha) is taken at a rising edge with start high and busy low.
// busy then stays high until its gap counter wraps to zero, and no new item is taken
// meanwhile; the spacing is set by the single result port, which sends the four
// matrix rows one per cycle. Sine and cosine of both angles come from a chain of 30
// CORDIC cells, each doing one micro-rotation of both angles per cycle, followed by a
// rounding stage and a product stage. Row 0 is then registered on the result ports and
// rows 1 to 3 follow on consecutive cycles, each marked by row_valid for one cycle;
// last_row flags row 3. The receiver cannot stall the block.
`default_nettype none

module dh_transform_matrix (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire signed [15:0]                joint_angle,
	input  wire signed [dhtm_pkg::WORD_W-1:0] joint_offset,
	input  wire signed [dhtm_pkg::WORD_W-1:0] link_length,
	input  wire signed [15:0]                link_twist,
	output logic                             row_valid,
	output logic [1:0]                       row_index,
	output logic signed [dhtm_pkg::WORD_W-1:0] cell_col0,
	output logic signed [dhtm_pkg::WORD_W-1:0] cell_col1,
	output logic signed [dhtm_pkg::WORD_W-1:0] cell_col2,
	output logic signed [dhtm_pkg::WORD_W-1:0] cell_col3,
	output logic                             last_row
);
	import dhtm_pkg::*;

	logic       accept;
	logic [1:0] gap_q;
	fold_t      fold_t_w;
	fold_t      fold_a_w;

	lane_t th_c   [STAGES+1];
	lane_t al_c   [STAGES+1];
	side_t side_c [STAGES+1];

	assign busy   = (gap_q != 2'd0);
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (accept || busy) begin
			gap_q <= gap_q + 2'd1;
		end
	end

	assign fold_t_w = fold_angle(joint_angle[ANGLE_BITS-1:0]);
	assign fold_a_w = fold_angle(link_twist[ANGLE_BITS-1:0]);

	always_comb begin
		th_c[0]          = fold_t_w.lane;
		al_c[0]          = fold_a_w.lane;
		side_c[0].valid  = accept;
		side_c[0].flip_t = fold_t_w.flip;
		side_c[0].flip_a = fold_a_w.flip;
		side_c[0].d      = joint_offset;
		side_c[0].r      = link_length;
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		dhtm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (SHIFT_W'(i)),
			.atan     (ATAN_TURN[i]),
			.th_in    (th_c[i]),
			.al_in    (al_c[i]),
			.side_in  (side_c[i]),
			.th_out   (th_c[i+1]),
			.al_out   (al_c[i+1]),
			.side_out (side_c[i+1])
		);
	end

	dhtm_row_out u_row_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.th_in     (th_c[STAGES]),
		.al_in     (al_c[STAGES]),
		.side_in   (side_c[STAGES]),
		.row_valid (row_valid),
		.row_index (row_index),
		.cell_col0 (cell_col0),
		.cell_col1 (cell_col1),
		.cell_col2 (cell_col2),
		.cell_col3 (cell_col3),
		.last_row  (last_row)
	);

	// an accepted item holds off the next until busy falls
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy ##1 busy ##1 busy ##1 !busy)
		else $error("busy window wrong");

	// busy only rises from an accept
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(accept))
		else $error("busy without accept");

	// the chain valid follows the accepting edge
	a_chain_entry: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> side_c[1].valid)
		else $error("item lost at chain entry");

endmodule

`default_nettype wire
